/* rtl/s128alu_pkg.sv */
// Shared types and codes for the signed 128-bit integer ALU.
// No dependencies; every file of the block but s128alu_if imports this package.
package s128alu_pkg;

    localparam int FULL_BITS = 128;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_NOT = 4'd8,
        OP_NEG = 4'd9,
        OP_SHL = 4'd10,
        OP_SAR = 4'd11,
        OP_ROL = 4'd12,
        OP_ROR = 4'd13,
        OP_CMP = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    localparam logic signed [1:0] ORD_LESS    = 2'sb11;
    localparam logic signed [1:0] ORD_EQUAL   = 2'sb00;
    localparam logic signed [1:0] ORD_GREATER = 2'sb01;

    typedef struct packed {
        op_t                  op;
        logic                 na;
        logic                 nb;
        logic                 min_by_m1;
        logic                 b_zero;
        logic [FULL_BITS-1:0] res;
        logic [1:0]           order;
        status_t              status;
    } ctl_t;

endpackage

/* rtl/s128alu_if.sv */
// Handshake channels of the signed 128-bit integer ALU.
// Depends on nothing; used by the top level.
interface s128alu_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [63:0] a_high;
    logic [63:0] a_low;
    logic [63:0] b_high;
    logic [63:0] b_low;
    logic [6:0]  shift_amount;

    modport source(output valid, operation, a_high, a_low, b_high, b_low, shift_amount,
                   input ready);
    modport sink(input valid, operation, a_high, a_low, b_high, b_low, shift_amount,
                 output ready);
endinterface

interface s128alu_rsp_if;
    logic              valid;
    logic              ready;
    logic [63:0]       result_high;
    logic [63:0]       result_low;
    logic [63:0]       rem_high;
    logic [63:0]       rem_low;
    logic signed [1:0] order;
    logic [1:0]        status;

    modport source(output valid, result_high, result_low, rem_high, rem_low, order, status,
                   input ready);
    modport sink(input valid, result_high, result_low, rem_high, rem_low, order, status,
                 output ready);
endinterface

/* rtl/s128alu_entry.sv */
// Entry stage: decodes an item, computes the operations other than multiply and divide, and
// prepares magnitudes for the multiply/divide cell chain. Uses s128alu_pkg.
module s128alu_entry #(
    parameter int OPERAND_BITS = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [3:0]                operation,
    input  logic [127:0]              a_full,
    input  logic [127:0]              b_full,
    input  logic [6:0]                shift_amount,
    output logic                      out_valid,
    output s128alu_pkg::ctl_t         out_ctl,
    output logic [OPERAND_BITS-1:0]   out_x,
    output logic [OPERAND_BITS-1:0]   out_y
);
    import s128alu_pkg::*;

    localparam int W = OPERAND_BITS;
    localparam logic [7:0] W8 = 8'(OPERAND_BITS);
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    function automatic logic [FULL_BITS-1:0] sx(input logic [W-1:0] v);
        sx = FULL_BITS'($signed(v));
    endfunction

    logic [W-1:0] a, b, sum, dif, nega, shl_v, sar_v, rot_v;
    logic         na, nb;
    logic [7:0]   sh8, rot_r, rot_l;
    op_t          op;
    ctl_t         ctl;

    logic         valid_reg;
    ctl_t         ctl_reg;
    logic [W-1:0] x_reg, y_reg;

    assign op    = op_t'(operation);
    assign a     = a_full[W-1:0];
    assign b     = b_full[W-1:0];
    assign na    = a[W-1];
    assign nb    = b[W-1];
    assign sum   = a + b;
    assign dif   = a - b;
    assign nega  = -a;
    assign sh8   = {1'b0, shift_amount};
    assign shl_v = a << shift_amount;
    assign sar_v = W'($signed(a) >>> shift_amount);
    assign rot_r = (sh8 >= W8) ? sh8 - W8 : sh8;
    assign rot_l = (op == OP_ROR && rot_r != 8'd0) ? W8 - rot_r : rot_r;
    assign rot_v = (a << rot_l) | (a >> (W8 - rot_l));

    always_comb
    begin
        ctl           = '0;
        ctl.op        = op;
        ctl.na        = na;
        ctl.nb        = nb;
        ctl.min_by_m1 = (a == MIN_VAL) && (b == {W{1'b1}});
        ctl.b_zero    = (b == '0);
        ctl.order     = ORD_EQUAL;
        ctl.status    = ST_OK;
        unique case (op)
            OP_ADD:
            begin
                ctl.res = sx(sum);
                if (na == nb && sum[W-1] != na)
                    ctl.status = ST_OVF;
            end
            OP_SUB:
            begin
                ctl.res = sx(dif);
                if (na != nb && dif[W-1] != na)
                    ctl.status = ST_OVF;
            end
            OP_AND: ctl.res = sx(a & b);
            OP_OR:  ctl.res = sx(a | b);
            OP_XOR: ctl.res = sx(a ^ b);
            OP_NOT: ctl.res = sx(~a);
            OP_NEG:
            begin
                ctl.res = sx(nega);
                if (a == MIN_VAL)
                    ctl.status = ST_OVF;
            end
            OP_SHL: ctl.res = (sh8 >= W8) ? '0 : sx(shl_v);
            OP_SAR: ctl.res = (sh8 >= W8) ? {FULL_BITS{na}} : sx(sar_v);
            OP_ROL, OP_ROR: ctl.res = sx(rot_v);
            OP_CMP:
            begin
                if (na != nb)
                    ctl.order = na ? ORD_LESS : ORD_GREATER;
                else if (a != b)
                    ctl.order = (a > b) ? ORD_GREATER : ORD_LESS;
            end
            default: ctl.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl;
            x_reg   <= na ? nega : a;
            y_reg   <= nb ? W'(-b) : b;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
endmodule

/* rtl/s128alu_cell.sv */
// One cell of the chain: a shift-add multiply step or a restoring divide step
// on one operand bit, passing the item on to the next cell. Uses s128alu_pkg.
module s128alu_cell #(
    parameter int OPERAND_BITS = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  s128alu_pkg::ctl_t         in_ctl,
    input  logic [OPERAND_BITS-1:0]   in_x,
    input  logic [OPERAND_BITS-1:0]   in_y,
    input  logic [2*OPERAND_BITS-1:0] in_acc,
    output logic                      out_valid,
    output s128alu_pkg::ctl_t         out_ctl,
    output logic [OPERAND_BITS-1:0]   out_x,
    output logic [OPERAND_BITS-1:0]   out_y,
    output logic [2*OPERAND_BITS-1:0] out_acc
);
    import s128alu_pkg::*;

    localparam int W = OPERAND_BITS;

    logic [W:0]     part, trial;
    logic           fits, is_div;
    logic [2*W-1:0] addend, prod_next, acc_next;
    logic [W-1:0]   x_next;

    logic           valid_reg;
    ctl_t           ctl_reg;
    logic [W-1:0]   x_reg, y_reg;
    logic [2*W-1:0] acc_reg;

    assign part      = {in_acc[W-1:0], in_x[W-1]};
    assign fits      = part >= {1'b0, in_y};
    assign trial     = part - {1'b0, in_y};
    assign addend    = in_x[W-1] ? {{W{1'b0}}, in_y} : '0;
    assign prod_next = {in_acc[2*W-2:0], 1'b0} + addend;
    assign is_div    = (in_ctl.op == OP_DIV) || (in_ctl.op == OP_MOD);

    always_comb
    begin
        if (is_div)
        begin
            x_next   = {in_x[W-2:0], fits};
            acc_next = {{W{1'b0}}, fits ? trial[W-1:0] : part[W-1:0]};
        end
        else
        begin
            x_next   = {in_x[W-2:0], 1'b0};
            acc_next = prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            x_reg   <= x_next;
            y_reg   <= in_y;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
endmodule

/* rtl/s128alu_finish.sv */
// Output stage: applies signs and overflow rules to the chain's product or
// quotient and remainder, and holds the result item. Uses s128alu_pkg.
module s128alu_finish #(
    parameter int OPERAND_BITS = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  s128alu_pkg::ctl_t         in_ctl,
    input  logic [OPERAND_BITS-1:0]   in_x,
    input  logic [2*OPERAND_BITS-1:0] in_acc,
    output logic                      out_valid,
    output logic [127:0]              out_res,
    output logic [127:0]              out_rem,
    output logic [1:0]                out_order,
    output logic [1:0]                out_status
);
    import s128alu_pkg::*;

    localparam int W = OPERAND_BITS;
    localparam logic [2*W-1:0] POW = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

    function automatic logic [FULL_BITS-1:0] sx(input logic [W-1:0] v);
        sx = FULL_BITS'($signed(v));
    endfunction

    logic                 neg_q;
    logic [W-1:0]         low, mres, q, r;
    logic [FULL_BITS-1:0] res, rem;
    status_t              status;

    logic                 valid_reg;
    logic [FULL_BITS-1:0] res_reg, rem_reg;
    logic [1:0]           order_reg;
    status_t              status_reg;

    assign neg_q = in_ctl.na != in_ctl.nb;
    assign low   = in_acc[W-1:0];
    assign mres  = neg_q ? -low : low;
    assign q     = neg_q ? -in_x : in_x;
    assign r     = in_ctl.na ? -low : low;

    always_comb
    begin
        res    = in_ctl.res;
        rem    = '0;
        status = in_ctl.status;
        unique case (in_ctl.op)
            OP_MUL:
            begin
                res    = sx(mres);
                status = ((|in_acc[2*W-1:W-1]) && !(neg_q && in_acc == POW)) ? ST_OVF : ST_OK;
            end
            OP_DIV, OP_MOD:
            begin
                if (in_ctl.b_zero)
                begin
                    res    = '0;
                    status = ST_DIVZ;
                end
                else
                begin
                    rem = sx(r);
                    if (in_ctl.op == OP_DIV)
                    begin
                        res    = sx(q);
                        status = in_ctl.min_by_m1 ? ST_OVF : ST_OK;
                    end
                    else
                    begin
                        res    = sx(r);
                        status = ST_OK;
                    end
                end
            end
            default: res = in_ctl.res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg    <= res;
            rem_reg    <= rem;
            order_reg  <= in_ctl.order;
            status_reg <= status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_res    = res_reg;
    assign out_rem    = rem_reg;
    assign out_order  = order_reg;
    assign out_status = status_reg;
endmodule

/* rtl/signed_128bit_integer_alu.sv */
// Signed integer ALU on two's-complement operands of OPERAND_BITS bits.
// Depends on s128alu_pkg, s128alu_if, s128alu_entry, s128alu_cell, s128alu_finish.
//
// Each item on req carries an operation code, two operands as high and low
// 64-bit halves and a shift amount. Each item produces exactly one item on
// rsp with the result, the remainder for divide and modulo, the compare
// order and a status code.
// Every operation goes through the same pipeline: an entry register, a chain
// of OPERAND_BITS cells and an output register.
// Each cell retires one bit of a multiply or divide.
// One item is accepted per cycle while rsp is taken.
// The whole pipeline advances only when the output register is empty or
// being read; while rsp is stalled with a result waiting, req.ready is low
// and every item in flight holds its place.
// Reset clears all valid bits; the pipeline is empty after reset.
module signed_128bit_integer_alu #(
    parameter int OPERAND_BITS = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    s128alu_req_if.sink   req,
    s128alu_rsp_if.source rsp
);
    import s128alu_pkg::*;

    localparam int W = OPERAND_BITS;

    logic           en;
    logic           v   [0:W];
    ctl_t           ctl [0:W];
    logic [W-1:0]   x   [0:W];
    logic [W-1:0]   y   [0:W];
    logic [2*W-1:0] acc [0:W];
    logic [127:0]   res, rem;

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;
    assign acc[0]    = '0;

    s128alu_entry #(.OPERAND_BITS(W)) u_entry (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (req.valid),
        .operation    (req.operation),
        .a_full       ({req.a_high, req.a_low}),
        .b_full       ({req.b_high, req.b_low}),
        .shift_amount (req.shift_amount),
        .out_valid    (v[0]),
        .out_ctl      (ctl[0]),
        .out_x        (x[0]),
        .out_y        (y[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        s128alu_cell #(.OPERAND_BITS(W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[i]),
            .in_ctl    (ctl[i]),
            .in_x      (x[i]),
            .in_y      (y[i]),
            .in_acc    (acc[i]),
            .out_valid (v[i+1]),
            .out_ctl   (ctl[i+1]),
            .out_x     (x[i+1]),
            .out_y     (y[i+1]),
            .out_acc   (acc[i+1])
        );
    end

    s128alu_finish #(.OPERAND_BITS(W)) u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v[W]),
        .in_ctl     (ctl[W]),
        .in_x       (x[W]),
        .in_acc     (acc[W]),
        .out_valid  (rsp.valid),
        .out_res    (res),
        .out_rem    (rem),
        .out_order  (rsp.order),
        .out_status (rsp.status)
    );

    assign rsp.result_high = res[127:64];
    assign rsp.result_low  = res[63:0];
    assign rsp.rem_high    = rem[127:64];
    assign rsp.rem_low     = rem[63:0];

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_DIVZ |-> res == '0 && rem == '0)
        else $error("division by zero item carries a nonzero result");

    a_order_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.order != ORD_EQUAL |-> rsp.status == ST_OK && rem == '0)
        else $error("compare order set together with status or remainder");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.order != 2'sb10)
        else $error("invalid order code");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v[W]) && $stable(v[0]))
        else $error("pipeline moved while output stalled");
endmodule

/* sim/alu_result_checker.sv */
// Checker for the signed 128-bit integer ALU: watches both channels, predicts each result
// and compares all of its fields. Depends on s128alu_pkg and the interfaces in s128alu_if.
module alu_result_checker (
    input  logic   clk,
    s128alu_req_if req,
    s128alu_rsp_if rsp,
    output int     fail_count,
    output int     pending,
    output int     checked_count
);
    import s128alu_pkg::*;

    typedef struct packed {
        logic [127:0]      res;
        logic [127:0]      rem;
        logic signed [1:0] order;
        logic [1:0]        status;
    } alu_outcome_t;

    alu_outcome_t expected_results[$];

    function automatic alu_outcome_t predict_alu(logic [3:0] op, logic [127:0] a,
                                                 logic [127:0] b, logic [6:0] sh);
        alu_outcome_t o;
        logic [127:0] minv;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] q;
        logic [127:0] r;
        logic [255:0] prod;
        logic         na;
        logic         nb;
        minv = {1'b1, 127'b0};
        o = '0;
        na = a[127];
        nb = b[127];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        case (op_t'(op))
            OP_ADD:
            begin
                o.res = a + b;
                if (na == nb && o.res[127] != na) o.status = ST_OVF;
            end
            OP_SUB:
            begin
                o.res = a - b;
                if (na != nb && o.res[127] != na) o.status = ST_OVF;
            end
            OP_MUL:
            begin
                prod = {128'b0, ma} * {128'b0, mb};
                o.res = (na != nb) ? -prod[127:0] : prod[127:0];
                if (prod[255:127] != 0 && !(na != nb && prod == {128'b0, minv}))
                    o.status = ST_OVF;
            end
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                begin
                    o.status = ST_DIVZ;
                end
                else
                begin
                    q = ma / mb;
                    r = ma % mb;
                    if (na != nb) q = -q;
                    if (na) r = -r;
                    o.rem = r;
                    if (op == OP_DIV)
                    begin
                        o.res = q;
                        if (a == minv && b == '1) o.status = ST_OVF;
                    end
                    else
                    begin
                        o.res = r;
                    end
                end
            end
            OP_AND: o.res = a & b;
            OP_OR:  o.res = a | b;
            OP_XOR: o.res = a ^ b;
            OP_NOT: o.res = ~a;
            OP_NEG:
            begin
                o.res = -a;
                if (a == minv) o.status = ST_OVF;
            end
            OP_SHL: o.res = a << sh;
            OP_SAR: o.res = $signed(a) >>> sh;
            OP_ROL: o.res = (sh == 0) ? a : ((a << sh) | (a >> (128 - sh)));
            OP_ROR: o.res = (sh == 0) ? a : ((a >> sh) | (a << (128 - sh)));
            OP_CMP:
            begin
                if ($signed(a) < $signed(b)) o.order = ORD_LESS;
                else if ($signed(a) > $signed(b)) o.order = ORD_GREATER;
                else o.order = ORD_EQUAL;
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    initial
    begin
        fail_count = 0;
        checked_count = 0;
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        alu_outcome_t got;
        alu_outcome_t want;
        alu_outcome_t pred;
        if (req.valid && req.ready)
        begin
            pred = predict_alu(req.operation, {req.a_high, req.a_low},
                               {req.b_high, req.b_low}, req.shift_amount);
            expected_results = {expected_results, pred};
        end
        if (rsp.valid && rsp.ready)
        begin
            got = {rsp.result_high, rsp.result_low, rsp.rem_high, rsp.rem_low,
                   rsp.order, rsp.status};
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result item: res=%h rem=%h order=%0d status=%0d",
                             got.res, got.rem, got.order, got.status);
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"Mismatch on result %0d: exp res=%h rem=%h ord=%0d st=%0d,",
                                  " got res=%h rem=%h ord=%0d st=%0d"},
                                 checked_count, want.res, want.rem, want.order, want.status,
                                 got.res, got.rem, got.order, got.status);
                end
            end
        end
    end
endmodule

/* sim/tb_signed_128bit_integer_alu.sv */
// Testbench top for the signed 128-bit integer ALU: directed and random items under
// varying idle patterns. Depends on s128alu_pkg, s128alu_if, alu_result_checker and the ALU.
module tb_signed_128bit_integer_alu;
    import s128alu_pkg::*;

    localparam logic [127:0] MIN_VAL = {1'b1, 127'b0};
    localparam logic [127:0] MAX_VAL = {1'b0, {127{1'b1}}};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked_count;
    int   sent_count;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_done;

    s128alu_req_if req_ch();
    s128alu_rsp_if rsp_ch();

    signed_128bit_integer_alu i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    alu_result_checker i_checker (
        .clk           (clk),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #4000000;
        $display("signed_128bit_integer_alu verification failed");
        $finish;
    end

    function automatic logic [127:0] random_operand();
        logic [127:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = 128'd1;
            2: v = '1;
            3: v = MIN_VAL;
            4: v = MAX_VAL;
            5: v = {{112{$urandom_range(1) == 1}}, 16'($urandom)};
            default: v = {$urandom, $urandom, $urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_item(logic [3:0] op, logic [127:0] a, logic [127:0] b,
                             logic [6:0] sh);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.a_high       <= a[127:64];
        req_ch.a_low        <= a[63:0];
        req_ch.b_high       <= b[127:64];
        req_ch.b_low        <= b[63:0];
        req_ch.shift_amount <= sh;
        do @(posedge clk); while (!req_ch.ready);
        sent_count++;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_count >= 900)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        logic [6:0] sh;
        int         phase;
        int         n;
        rst_n = 1'b0;
        sent_count = 0;
        hold_done = 1'b0;
        tx_idle_pct = 14;
        rx_idle_pct = 62;
        req_ch.valid <= 1'b0;
        req_ch.operation <= '0;
        req_ch.a_high <= '0;
        req_ch.a_low <= '0;
        req_ch.b_high <= '0;
        req_ch.b_low <= '0;
        req_ch.shift_amount <= '0;
        rsp_ch.ready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_ADD, MAX_VAL, MAX_VAL, 7'd0);
        send_item(OP_ADD, MIN_VAL, '1, 7'd0);
        send_item(OP_SUB, 128'd0, MIN_VAL, 7'd0);
        send_item(OP_SUB, '1, MIN_VAL, 7'd0);
        send_item(OP_MUL, MAX_VAL, 128'd2, 7'd0);
        send_item(OP_MUL, MIN_VAL, 128'd1, 7'd0);
        send_item(OP_MUL, MIN_VAL, '1, 7'd0);
        send_item(OP_DIV, MAX_VAL, 128'd0, 7'd0);
        send_item(OP_MOD, MAX_VAL, 128'd0, 7'd0);
        send_item(OP_DIV, MIN_VAL, '1, 7'd0);
        send_item(OP_MOD, MIN_VAL, '1, 7'd0);
        send_item(OP_DIV, -128'd7, 128'd2, 7'd0);
        send_item(OP_DIV, MAX_VAL, {2'b01, 126'h5}, 7'd0);
        send_item(OP_AND, MIN_VAL, '1, 7'd0);
        send_item(OP_OR, MIN_VAL, MAX_VAL, 7'd0);
        send_item(OP_XOR, '1, MAX_VAL, 7'd0);
        send_item(OP_NOT, MIN_VAL, '0, 7'd0);
        send_item(OP_NEG, MIN_VAL, '0, 7'd0);
        send_item(OP_SHL, '1, '0, 7'd127);
        send_item(OP_SAR, MIN_VAL, '0, 7'd127);
        send_item(OP_ROL, MIN_VAL, '0, 7'd1);
        send_item(OP_ROR, 128'd1, '0, 7'd127);
        send_item(OP_CMP, MIN_VAL, MAX_VAL, 7'd0);
        send_item(OP_CMP, MAX_VAL, MAX_VAL, 7'd0);
        send_item(4'd15, '1, '1, 7'd127);

        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 62 : 0;
            rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 14 : 0;
            for (n = 0; n < 600; n++)
            begin
                case ($urandom_range(5))
                    0: sh = 7'd0;
                    1: sh = 7'd127;
                    default: sh = 7'($urandom_range(127));
                endcase
                send_item(4'($urandom_range(15)), random_operand(), random_operand(), sh);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (140) @(posedge clk);
        $display("Sent %0d items and checked %0d results across three idle patterns.",
                 sent_count, checked_count);
        $display("Mismatches: %0d.", fail_count);
        if (fail_count == 0)
            $display("signed_128bit_integer_alu verification clean");
        else
            $display("signed_128bit_integer_alu verification failed");
        $finish;
    end
endmodule
